// ===== design/pmfr_pkg.sv =====
// Shared types and constants of the phone module frame receiver.
package pmfr_pkg;

  localparam int FrameDepthDef = 32;
  localparam int DigitDepthDef = 32;
  localparam int QueueDepth    = 2;

  localparam logic [7:0] SyncByte   = 8'hFA;
  localparam logic [7:0] DialHead0  = 8'h89;
  localparam logic [7:0] DialHead1  = 8'h8D;
  localparam logic [7:0] DialHead2  = 8'h04;
  localparam logic [7:0] BusyHead0  = 8'h89;
  localparam logic [7:0] BusyHead1  = 8'h89;
  localparam logic [7:0] BusyHead2  = 8'h33;
  localparam logic [7:0] DtmfHead   = 8'h8A;
  localparam logic [7:0] RingHead   = 8'h80;
  localparam logic [7:0] LineHead   = 8'h70;
  localparam logic [7:0] DigitBias  = 8'd48;
  localparam logic [7:0] DigitTen   = 8'h0A;
  localparam logic [7:0] NoDigit    = 8'hFF;

  typedef enum logic [1:0] {
    CMD_RX        = 2'd0,
    CMD_POP       = 2'd1,
    CMD_CLR_FIFO  = 2'd2,
    CMD_CLR_FLAGS = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_DIAL  = 3'd1,
    KIND_DTMF  = 3'd2,
    KIND_RING  = 3'd3,
    KIND_LINE  = 3'd4,
    KIND_BUSY  = 3'd5,
    KIND_OTHER = 3'd6
  } kind_e;

  // Classified transaction handed from the front end to the back end.
  typedef struct packed {
    cmd_e       cmd;
    logic       frame_done;
    kind_e      kind;
    logic [7:0] digit;
  } event_t;

  // Result fields as seen by the output channel.
  typedef struct packed {
    logic       frame_done;
    kind_e      kind;
    logic [7:0] popped;
    logic       dial_seen;
    logic       busy_seen;
    logic       ring_seen;
    logic       line_seen;
    logic       dtmf_pending;
    logic [7:0] ring_total;
    logic [5:0] dtmf_level;
  } result_t;

endpackage

// ===== design/pmfr_front.sv =====
// Front end: frame assembly, checksum and frame classification.
module pmfr_front #(
  parameter int FRAME_DEPTH = pmfr_pkg::FrameDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  pmfr_pkg::cmd_e   cmd_i,
  input  logic [7:0]       rx_byte_i,
  output pmfr_pkg::event_t ev_o
);

  localparam int LW = $clog2(FRAME_DEPTH);

  logic          receiving_q, receiving_d;
  logic [LW-1:0] len_q, len_d;
  logic [7:0]    xor_q, xor_d;
  logic [7:0]    head_q [3];
  logic [7:0]    head_d [3];
  logic          done;
  logic [7:0]    digit;
  pmfr_pkg::kind_e kind;

  always_comb begin
    receiving_d = receiving_q;
    len_d       = len_q;
    xor_d       = xor_q;
    head_d      = head_q;
    done        = 1'b0;
    if (cmd_i == pmfr_pkg::CMD_RX) begin
      if (rx_byte_i == pmfr_pkg::SyncByte) begin
        receiving_d = 1'b1;
        len_d       = '0;
        xor_d       = '0;
      end else if (receiving_q) begin
        if (({1'b0, len_q} + 1'b1) >= (LW+1)'(FRAME_DEPTH)) begin
          // store full: abort the frame
          receiving_d = 1'b0;
          len_d       = '0;
          xor_d       = '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (len_q == LW'(i)) head_d[i] = rx_byte_i;
          end
          len_d = len_q + 1'b1;
          if (xor_q == rx_byte_i) begin
            done        = 1'b1;
            receiving_d = 1'b0;
            len_d       = '0;
            xor_d       = '0;
          end else begin
            xor_d = xor_q ^ rx_byte_i;
          end
        end
      end
    end
  end

  // Match the head bytes, stale ones included, in priority order.
  always_comb begin
    digit = head_d[1] - pmfr_pkg::DigitBias;
    if (digit == pmfr_pkg::DigitTen) digit = '0;
    if (!done) begin
      kind = pmfr_pkg::KIND_NONE;
    end else if (head_d[0] == pmfr_pkg::DialHead0 && head_d[1] == pmfr_pkg::DialHead1 &&
                 head_d[2] == pmfr_pkg::DialHead2) begin
      kind = pmfr_pkg::KIND_DIAL;
    end else if (head_d[0] == pmfr_pkg::DtmfHead) begin
      kind = pmfr_pkg::KIND_DTMF;
    end else if (head_d[0] == pmfr_pkg::RingHead && head_d[1] == pmfr_pkg::RingHead) begin
      kind = pmfr_pkg::KIND_RING;
    end else if (head_d[0] == pmfr_pkg::LineHead) begin
      kind = pmfr_pkg::KIND_LINE;
    end else if (head_d[0] == pmfr_pkg::BusyHead0 && head_d[1] == pmfr_pkg::BusyHead1 &&
                 head_d[2] == pmfr_pkg::BusyHead2) begin
      kind = pmfr_pkg::KIND_BUSY;
    end else begin
      kind = pmfr_pkg::KIND_OTHER;
    end
  end

  assign ev_o.cmd        = cmd_i;
  assign ev_o.frame_done = done;
  assign ev_o.kind       = kind;
  assign ev_o.digit      = digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      len_q       <= '0;
      xor_q       <= '0;
      for (int i = 0; i < 3; i++) head_q[i] <= '0;
    end else if (accept_i) begin
      receiving_q <= receiving_d;
      len_q       <= len_d;
      xor_q       <= xor_d;
      head_q      <= head_d;
    end
  end

endmodule

// ===== design/pmfr_queue.sv =====
// Short event queue between the front end and the back end.
module pmfr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pmfr_pkg::event_t ev_i,
  output logic             ready_o,
  output logic             valid_o,
  output pmfr_pkg::event_t ev_o,
  input  logic             pop_i
);

  localparam int QD = pmfr_pkg::QueueDepth;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  pmfr_pkg::event_t slot_q [QD];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign ready_o = (cnt_q != CW'(QD));
  assign valid_o = (cnt_q != '0);
  assign ev_o    = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= ev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QD - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PW'(QD - 1)) ? '0 : rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/pmfr_back.sv =====
// Back end: status flags, ring count, DTMF digit FIFO and result register.
module pmfr_back #(
  parameter int DIGIT_DEPTH = pmfr_pkg::DigitDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ev_valid_i,
  input  pmfr_pkg::event_t  ev_i,
  output logic              ev_pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output pmfr_pkg::result_t res_o
);

  localparam int AW = $clog2(DIGIT_DEPTH);
  localparam int CW = $clog2(DIGIT_DEPTH + 1);

  logic [7:0]    mem [DIGIT_DEPTH];
  logic [AW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          dial_q, dial_d, busy_q, busy_d, ring_q, ring_d, line_q, line_d;
  logic          dtmf_q, dtmf_d;
  logic [7:0]    ring_cnt_q, ring_cnt_d;
  logic          valid_q;
  logic          done_q;
  pmfr_pkg::kind_e kind_q;
  logic          pop_hit_q;
  logic [7:0]    pop_data_q;
  logic          take, push, pop_ok;

  // Take a new event whenever the result slot is free or being drained.
  assign take     = ev_valid_i && (!valid_q || res_ready_i);
  assign ev_pop_o = take;

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    cnt_d      = cnt_q;
    dial_d     = dial_q;
    busy_d     = busy_q;
    ring_d     = ring_q;
    line_d     = line_q;
    dtmf_d     = dtmf_q;
    ring_cnt_d = ring_cnt_q;
    push       = 1'b0;
    pop_ok     = 1'b0;
    case (ev_i.cmd)
      pmfr_pkg::CMD_RX: begin
        case (ev_i.kind)
          pmfr_pkg::KIND_DIAL: dial_d = 1'b1;
          pmfr_pkg::KIND_DTMF: begin
            dtmf_d = 1'b1;
            if (cnt_q != CW'(DIGIT_DEPTH)) begin
              push     = 1'b1;
              cnt_d    = cnt_q + 1'b1;
              wr_ptr_d = (wr_ptr_q == AW'(DIGIT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
            end
          end
          pmfr_pkg::KIND_RING: begin
            ring_d     = 1'b1;
            ring_cnt_d = ring_cnt_q + 1'b1;
          end
          pmfr_pkg::KIND_LINE: line_d = 1'b1;
          pmfr_pkg::KIND_BUSY: busy_d = 1'b1;
          default: ;
        endcase
      end
      pmfr_pkg::CMD_POP: begin
        if (dtmf_q && cnt_q != '0) begin
          pop_ok   = 1'b1;
          rd_ptr_d = (rd_ptr_q == AW'(DIGIT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
          cnt_d    = cnt_q - 1'b1;
          if (cnt_q == CW'(1)) dtmf_d = 1'b0;
        end
      end
      pmfr_pkg::CMD_CLR_FIFO: begin
        rd_ptr_d = '0;
        wr_ptr_d = '0;
        cnt_d    = '0;
        dtmf_d   = 1'b0;
      end
      pmfr_pkg::CMD_CLR_FLAGS: begin
        dial_d     = 1'b0;
        busy_d     = 1'b0;
        ring_d     = 1'b0;
        line_d     = 1'b0;
        ring_cnt_d = '0;
      end
      default: ;
    endcase
  end

  // Digit store, written on push, read into the result register on pop.
  always_ff @(posedge clk_i) begin
    if (take && push)   mem[wr_ptr_q] <= ev_i.digit;
    if (take && pop_ok) pop_data_q    <= mem[rd_ptr_q];
    if (take) begin
      done_q <= ev_i.frame_done;
      kind_q <= ev_i.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      pop_hit_q  <= 1'b0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      cnt_q      <= '0;
      dial_q     <= 1'b0;
      busy_q     <= 1'b0;
      ring_q     <= 1'b0;
      line_q     <= 1'b0;
      dtmf_q     <= 1'b0;
      ring_cnt_q <= '0;
    end else begin
      if (take) begin
        valid_q    <= 1'b1;
        pop_hit_q  <= pop_ok;
        rd_ptr_q   <= rd_ptr_d;
        wr_ptr_q   <= wr_ptr_d;
        cnt_q      <= cnt_d;
        dial_q     <= dial_d;
        busy_q     <= busy_d;
        ring_q     <= ring_d;
        line_q     <= line_d;
        dtmf_q     <= dtmf_d;
        ring_cnt_q <= ring_cnt_d;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // State only moves when a new result is loaded, so it mirrors the held result.
  assign res_valid_o       = valid_q;
  assign res_o.frame_done   = done_q;
  assign res_o.kind         = kind_q;
  assign res_o.popped       = pop_hit_q ? pop_data_q : pmfr_pkg::NoDigit;
  assign res_o.dial_seen    = dial_q;
  assign res_o.busy_seen    = busy_q;
  assign res_o.ring_seen    = ring_q;
  assign res_o.line_seen    = line_q;
  assign res_o.dtmf_pending = dtmf_q;
  assign res_o.ring_total   = ring_cnt_q;
  assign res_o.dtmf_level   = 6'(cnt_q);

endmodule

// ===== design/phone_module_frame_receiver.sv =====
// Top level of the phone module frame receiver.
//
// Channel   Direction  Transaction
// s_axis    in         one command with its received byte
// m_axis    out        one result: frame status, popped digit, flags, counts
//
// One transaction in, one result out, one per cycle sustained while m_axis_tready
// holds; the front end settles framing and classification in the accepting cycle,
// the event is registered in the event queue and the back end then applies it to
// flags and the digit FIFO in its registers, which hold the result. A two-entry
// event queue and the result register let the input keep flowing while a result
// waits. Reset clears all control state at once; the digit store holds no reset value.
module phone_module_frame_receiver #(
  parameter int FRAME_DEPTH = pmfr_pkg::FrameDepthDef,
  parameter int DIGIT_DEPTH = pmfr_pkg::DigitDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] frame_kind, [10:3] popped_digit,
                                      // [11] dial_tone_seen, [12] busy_seen,
                                      // [13] ring_seen, [14] line_ok_seen,
                                      // [15] dtmf_pending, [23:16] ring_total,
                                      // [29:24] dtmf_level, [31:30] zero
  output logic        m_axis_tlast    // frame_done
);

  pmfr_pkg::event_t  ev_in, ev_out;
  pmfr_pkg::result_t res;
  logic              q_ready, q_valid, q_pop, accept;

  // Accept a transaction whenever the queue has room.
  assign s_axis_tready = q_ready;
  assign accept        = s_axis_tvalid && q_ready;

  pmfr_front #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (pmfr_pkg::cmd_e'(s_axis_tuser)),
    .rx_byte_i (s_axis_tdata),
    .ev_o      (ev_in)
  );

  pmfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .ev_i    (ev_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .ev_o    (ev_out),
    .pop_i   (q_pop)
  );

  pmfr_back #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (q_valid),
    .ev_i        (ev_out),
    .ev_pop_o    (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tlast = res.frame_done;
  assign m_axis_tdata = {2'b00, res.dtmf_level, res.ring_total, res.dtmf_pending,
                         res.line_seen, res.ring_seen, res.busy_seen, res.dial_seen,
                         res.popped, res.kind};

  // A frame kind only accompanies a completed frame, checked at the queue input.
  a_kind_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (ev_in.frame_done == (ev_in.kind != pmfr_pkg::KIND_NONE)))
    else $error("frame kind and frame completion disagree");

  // A delivered DTMF frame leaves a digit pending.
  a_dtmf_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.kind == pmfr_pkg::KIND_DTMF) |-> res.dtmf_pending)
    else $error("DTMF frame without pending digit");

  // A delivered ring frame shows the ring flag.
  a_ring_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.kind == pmfr_pkg::KIND_RING) |-> res.ring_seen)
    else $error("ring frame without ring flag");

  // A popped digit implies the FIFO had one, so no digit shows on a frame result.
  a_pop_not_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.frame_done) |-> (res.popped == pmfr_pkg::NoDigit))
    else $error("digit popped on a frame result");

endmodule
